[rtl/core/tte_pkg.sv]
// Shared types and constants of the text terminal character engine.
// Holds geometry limits, character codes, action and state codes and the
// structs passed between the engine modules. Depends on nothing.
package tte_pkg;

   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 32;
   localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;

   localparam int CELL_W = 16;
   localparam int ADDR_W = 12;
   localparam int SIZE_W = 13;
   localparam int NC_W   = 8;
   localparam int NR_W   = 6;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;

   localparam logic [7:0] CH_NEWLINE   = 8'h0a;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_FLUSH     = 8'h04;
   localparam logic [7:0] CH_ESCAPE    = 8'h1b;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [NC_W-1:0] COLUMNS_RESET   = 8'd80;
   localparam logic [NR_W-1:0] ROWS_RESET      = 6'd25;
   localparam logic [7:0]      ATTRIBUTE_RESET = 8'h07;

   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_ROWS    = 1'b1;

   typedef enum logic [1:0] {
      ACT_PUT   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_CLEAR,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [NC_W-1:0]   nc;
      logic [NR_W-1:0]   nr;
      logic [ROW_W-1:0]  last_row;
      logic [COL_W-1:0]  last_col;
      logic [ROW_W-1:0]  row_c;
      logic [COL_W-1:0]  col_c;
      logic              row_last;
      logic              col_last;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] copies;
      logic [ADDR_W-1:0] cur_index;
   } geom_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CELL_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

[rtl/core/tte_cell_ram.sv]
// Cell buffer of the text terminal engine: one write port, one read port,
// registered read data. Depends on tte_pkg.
module tte_cell_ram (
   input  logic                         clock,
   input  tte_pkg::mem_req_type         mem_req,
   output logic [tte_pkg::CELL_W-1:0]   rd_data
);

   logic [tte_pkg::CELL_W-1:0] cells [tte_pkg::STORE_CELLS];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         cells[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data <= cells[mem_req.raddr];
      end
   end

endmodule

[rtl/core/tte_geom.sv]
// Effective screen geometry, clamped cursor and linear cell index.
// Combinational; depends on tte_pkg.
module tte_geom (
   input  logic [tte_pkg::NC_W-1:0]  csr_columns,
   input  logic [tte_pkg::NR_W-1:0]  csr_rows,
   input  logic [tte_pkg::ROW_W-1:0] cur_row,
   input  logic [tte_pkg::COL_W-1:0] cur_col,
   output tte_pkg::geom_type         geom
);

   logic [tte_pkg::NC_W-1:0]   nc;
   logic [tte_pkg::NR_W-1:0]   nr;
   logic [tte_pkg::NC_W-1:0]   nc_m1;
   logic [tte_pkg::NR_W-1:0]   nr_m1;
   logic [tte_pkg::ROW_W-1:0]  row_c;
   logic [tte_pkg::COL_W-1:0]  col_c;
   logic [tte_pkg::SIZE_W-1:0] prod;
   logic [tte_pkg::SIZE_W-1:0] row_base;
   logic [tte_pkg::SIZE_W-1:0] lin;
   logic [tte_pkg::SIZE_W-1:0] copies;

   always_comb begin
      // fold out-of-range register values into the usable range
      if (csr_columns == '0) begin
         nc = tte_pkg::NC_W'(1);
      end else if (csr_columns > tte_pkg::NC_W'(tte_pkg::MAX_COLUMNS)) begin
         nc = tte_pkg::NC_W'(tte_pkg::MAX_COLUMNS);
      end else begin
         nc = csr_columns;
      end
      if (csr_rows == '0) begin
         nr = tte_pkg::NR_W'(1);
      end else if (csr_rows > tte_pkg::NR_W'(tte_pkg::MAX_ROWS)) begin
         nr = tte_pkg::NR_W'(tte_pkg::MAX_ROWS);
      end else begin
         nr = csr_rows;
      end
      nc_m1 = nc - tte_pkg::NC_W'(1);
      nr_m1 = nr - tte_pkg::NR_W'(1);

      row_c = ({1'b0, cur_row} >= nr) ? nr_m1[tte_pkg::ROW_W-1:0] : cur_row;
      col_c = ({1'b0, cur_col} >= nc) ? nc_m1[tte_pkg::COL_W-1:0] : cur_col;

      prod     = tte_pkg::SIZE_W'(nc) * tte_pkg::SIZE_W'(nr);
      row_base = tte_pkg::SIZE_W'(row_c) * tte_pkg::SIZE_W'(nc);
      lin      = row_base + tte_pkg::SIZE_W'(col_c);
      copies   = prod - tte_pkg::SIZE_W'(nc);

      geom.nc        = nc;
      geom.nr        = nr;
      geom.last_row  = nr_m1[tte_pkg::ROW_W-1:0];
      geom.last_col  = nc_m1[tte_pkg::COL_W-1:0];
      geom.row_c     = row_c;
      geom.col_c     = col_c;
      geom.row_last  = (row_c == nr_m1[tte_pkg::ROW_W-1:0]);
      geom.col_last  = (col_c == nc_m1[tte_pkg::COL_W-1:0]);
      geom.size      = prod;
      geom.copies    = copies[tte_pkg::ADDR_W-1:0];
      geom.cur_index = lin[tte_pkg::ADDR_W-1:0];
   end

endmodule

[rtl/core/tte_ctrl.sv]
// Sequencer of the text terminal engine: cursor, color and escape state,
// item decode, scroll copy and clear sweeps over the cell buffer, and the
// result register. Depends on tte_pkg.
module tte_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic [7:0]                   req_char_byte,
   input  logic [7:0]                   req_fill_color,
   input  logic [tte_pkg::ADDR_W-1:0]   req_read_index,
   input  tte_pkg::geom_type            geom,
   output logic [tte_pkg::ROW_W-1:0]    cur_row,
   output logic [tte_pkg::COL_W-1:0]    cur_col,
   output tte_pkg::mem_req_type         mem_req,
   input  logic [tte_pkg::CELL_W-1:0]   rd_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tte_pkg::CELL_W-1:0]   rsp_cell_value,
   output logic [tte_pkg::ADDR_W-1:0]   rsp_cell_index,
   output logic                         rsp_cell_written,
   output logic [tte_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tte_pkg::COL_W-1:0]    rsp_cursor_column,
   output logic [7:0]                   rsp_current_color,
   output logic                         rsp_flush_request,
   output logic                         rsp_scrolled
);

   tte_pkg::state_type state_ff, state_in;

   logic [1:0]                 act_ff, act_in;
   logic [7:0]                 char_ff, char_in;
   logic [7:0]                 fill_ff, fill_in;
   logic [tte_pkg::ADDR_W-1:0] ridx_ff, ridx_in;

   logic [tte_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [tte_pkg::COL_W-1:0]  col_ff, col_in;
   logic [7:0]                 attr_ff, attr_in;
   logic                       esc_ff, esc_in;
   logic [tte_pkg::ADDR_W-1:0] cnt_ff, cnt_in;

   logic [tte_pkg::CELL_W-1:0] res_value_ff, res_value_in;
   logic [tte_pkg::ADDR_W-1:0] res_index_ff, res_index_in;
   logic                       res_written_ff, res_written_in;
   logic                       res_flush_ff, res_flush_in;
   logic                       res_scr_ff, res_scr_in;

   logic                       out_valid_ff, out_valid_in;
   logic [tte_pkg::CELL_W-1:0] out_value_ff, out_value_in;
   logic [tte_pkg::ADDR_W-1:0] out_index_ff, out_index_in;
   logic                       out_written_ff, out_written_in;
   logic [tte_pkg::ROW_W-1:0]  out_row_ff, out_row_in;
   logic [tte_pkg::COL_W-1:0]  out_col_ff, out_col_in;
   logic [7:0]                 out_color_ff, out_color_in;
   logic                       out_flush_ff, out_flush_in;
   logic                       out_scr_ff, out_scr_in;

   logic out_free;
   logic load_rsp;
   logic more_work;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tte_pkg::ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= tte_pkg::ATTRIBUTE_RESET;
         esc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         esc_ff       <= esc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      char_ff        <= char_in;
      fill_ff        <= fill_in;
      ridx_ff        <= ridx_in;
      cnt_ff         <= cnt_in;
      res_value_ff   <= res_value_in;
      res_index_ff   <= res_index_in;
      res_written_ff <= res_written_in;
      res_flush_ff   <= res_flush_in;
      res_scr_ff     <= res_scr_in;
      out_value_ff   <= out_value_in;
      out_index_ff   <= out_index_in;
      out_written_ff <= out_written_in;
      out_row_ff     <= out_row_in;
      out_col_ff     <= out_col_in;
      out_color_ff   <= out_color_in;
      out_flush_ff   <= out_flush_in;
      out_scr_ff     <= out_scr_in;
   end

   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      char_in        = char_ff;
      fill_in        = fill_ff;
      ridx_in        = ridx_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      attr_in        = attr_ff;
      esc_in         = esc_ff;
      cnt_in         = cnt_ff;
      res_value_in   = res_value_ff;
      res_index_in   = res_index_ff;
      res_written_in = res_written_ff;
      res_flush_in   = res_flush_ff;
      res_scr_in     = res_scr_ff;
      mem_req        = '0;
      load_rsp       = 1'b0;
      more_work      = 1'b0;
      out_free       = !out_valid_ff || !rsp_stall;

      unique case (state_ff)
         tte_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               char_in  = req_char_byte;
               fill_in  = req_fill_color;
               ridx_in  = req_read_index;
               state_in = tte_pkg::ST_EXEC;
            end
         end

         tte_pkg::ST_EXEC: begin
            // cursor clamps to the current geometry on every item
            row_in         = geom.row_c;
            col_in         = geom.col_c;
            res_value_in   = '0;
            res_index_in   = '0;
            res_written_in = 1'b0;
            res_flush_in   = 1'b0;
            res_scr_in     = 1'b0;
            cnt_in         = '0;
            case (act_ff)
               tte_pkg::ACT_PUT: begin
                  if (esc_ff) begin
                     attr_in = char_ff;
                     esc_in  = 1'b0;
                  end else begin
                     case (char_ff)
                        tte_pkg::CH_NEWLINE: begin
                           col_in = '0;
                           if (geom.row_last) begin
                              res_scr_in = 1'b1;
                              more_work  = 1'b1;
                              state_in   = tte_pkg::ST_SCROLL;
                           end else begin
                              row_in = geom.row_c + tte_pkg::ROW_W'(1);
                           end
                        end
                        tte_pkg::CH_BACKSPACE: begin
                           if (geom.col_c == '0) begin
                              if (geom.row_c != '0) begin
                                 col_in = geom.last_col;
                                 row_in = geom.row_c - tte_pkg::ROW_W'(1);
                              end
                           end else begin
                              col_in = geom.col_c - tte_pkg::COL_W'(1);
                           end
                        end
                        tte_pkg::CH_FLUSH: begin
                           res_flush_in = 1'b1;
                        end
                        tte_pkg::CH_ESCAPE: begin
                           esc_in = 1'b1;
                        end
                        default: begin
                           mem_req.we     = 1'b1;
                           mem_req.waddr  = geom.cur_index;
                           mem_req.wdata  = {attr_ff, char_ff};
                           res_value_in   = {attr_ff, char_ff};
                           res_index_in   = geom.cur_index;
                           res_written_in = 1'b1;
                           if (geom.col_last) begin
                              col_in = '0;
                              if (geom.row_last) begin
                                 res_scr_in = 1'b1;
                                 more_work  = 1'b1;
                                 state_in   = tte_pkg::ST_SCROLL;
                              end else begin
                                 row_in = geom.row_c + tte_pkg::ROW_W'(1);
                              end
                           end else begin
                              col_in = geom.col_c + tte_pkg::COL_W'(1);
                           end
                        end
                     endcase
                  end
               end
               tte_pkg::ACT_CLEAR: begin
                  attr_in   = fill_ff;
                  row_in    = '0;
                  col_in    = '0;
                  more_work = 1'b1;
                  state_in  = tte_pkg::ST_CLEAR;
               end
               tte_pkg::ACT_READ: begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = ridx_ff;
                  res_index_in  = ridx_ff;
                  more_work     = 1'b1;
                  state_in      = tte_pkg::ST_READ_WAIT;
               end
               default: begin
               end
            endcase
            if (!more_work) begin
               if (out_free) begin
                  load_rsp = 1'b1;
                  state_in = tte_pkg::ST_IDLE;
               end else begin
                  state_in = tte_pkg::ST_DONE;
               end
            end
         end

         tte_pkg::ST_SCROLL: begin
            // read cell cnt+nc, write it back at cnt in the next cycle
            cnt_in = cnt_ff + tte_pkg::ADDR_W'(1);
            if (cnt_ff < geom.copies) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = cnt_ff + tte_pkg::ADDR_W'(geom.nc);
            end
            if (cnt_ff != '0) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = cnt_ff - tte_pkg::ADDR_W'(1);
               mem_req.wdata = rd_data;
            end
            if (cnt_ff == geom.copies) begin
               state_in = tte_pkg::ST_DONE;
            end
         end

         tte_pkg::ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = cnt_ff;
            mem_req.wdata = {attr_ff, tte_pkg::CH_SPACE};
            cnt_in        = cnt_ff + tte_pkg::ADDR_W'(1);
            if ({1'b0, cnt_ff} == geom.size - tte_pkg::SIZE_W'(1)) begin
               state_in = tte_pkg::ST_DONE;
            end
         end

         tte_pkg::ST_READ_WAIT: begin
            res_value_in = rd_data;
            state_in     = tte_pkg::ST_DONE;
         end

         tte_pkg::ST_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = tte_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tte_pkg::ST_IDLE;
         end
      endcase

      out_valid_in   = load_rsp || (out_valid_ff && rsp_stall);
      out_value_in   = load_rsp ? res_value_in   : out_value_ff;
      out_index_in   = load_rsp ? res_index_in   : out_index_ff;
      out_written_in = load_rsp ? res_written_in : out_written_ff;
      out_row_in     = load_rsp ? row_in         : out_row_ff;
      out_col_in     = load_rsp ? col_in         : out_col_ff;
      out_color_in   = load_rsp ? attr_in        : out_color_ff;
      out_flush_in   = load_rsp ? res_flush_in   : out_flush_ff;
      out_scr_in     = load_rsp ? res_scr_in     : out_scr_ff;
   end

   assign req_stall         = (state_ff != tte_pkg::ST_IDLE);
   assign cur_row           = row_ff;
   assign cur_col           = col_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_cell_value    = out_value_ff;
   assign rsp_cell_index    = out_index_ff;
   assign rsp_cell_written  = out_written_ff;
   assign rsp_cursor_row    = out_row_ff;
   assign rsp_cursor_column = out_col_ff;
   assign rsp_current_color = out_color_ff;
   assign rsp_flush_request = out_flush_ff;
   assign rsp_scrolled      = out_scr_ff;

endmodule

[rtl/core/text_terminal_char_engine.sv]
// Text terminal character engine: a 4096-cell text buffer in one single-port-write
// synchronous RAM with a cursor, color attribute and escape flag; handles one item
// at a time. A read waits for its registered RAM read data before its result is
// loaded. A newline or a put that runs off the bottom row scrolls the buffer: a
// copy sweep through the RAM, one cell per cycle. A clear fills columns*rows cells
// one per cycle. The single RAM write port sets the pace of these sweeps. The result
// register lets a new item be taken while the previous result still waits. The
// buffer powers up undefined; cells outside the range written by a clear or a put
// read back undefined. Depends on tte_pkg, tte_geom, tte_ctrl and tte_cell_ram.
module text_terminal_char_engine (
   input  logic         clock,
   input  logic         reset,
   // input items
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_action,
   input  logic [7:0]   req_char_byte,
   input  logic [7:0]   req_fill_color,
   input  logic [11:0]  req_read_index,
   // result items
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [15:0]  rsp_cell_value,
   output logic [11:0]  rsp_cell_index,
   output logic         rsp_cell_written,
   output logic [4:0]   rsp_cursor_row,
   output logic [6:0]   rsp_cursor_column,
   output logic [7:0]   rsp_current_color,
   output logic         rsp_flush_request,
   output logic         rsp_scrolled,
   // configuration registers
   input  logic         csr_write_enable,
   input  logic         csr_index,
   input  logic [7:0]   csr_write_data
);

   logic [tte_pkg::NC_W-1:0]   columns_ff, columns_in;
   logic [tte_pkg::NR_W-1:0]   rows_ff, rows_in;
   logic [tte_pkg::ROW_W-1:0]  cur_row;
   logic [tte_pkg::COL_W-1:0]  cur_col;
   logic [tte_pkg::CELL_W-1:0] rd_data;
   tte_pkg::geom_type          geom;
   tte_pkg::mem_req_type       mem_req;

   // Geometry registers: write only while the engine is idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= tte_pkg::COLUMNS_RESET;
         rows_ff    <= tte_pkg::ROWS_RESET;
      end else begin
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
      end
   end

   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tte_pkg::CSR_COLUMNS: columns_in = csr_write_data;
            tte_pkg::CSR_ROWS:    rows_in    = csr_write_data[tte_pkg::NR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective geometry, clamped cursor and the cursor's linear cell index.
   tte_geom u_geom (
      .csr_columns (columns_ff),
      .csr_rows    (rows_ff),
      .cur_row     (cur_row),
      .cur_col     (cur_col),
      .geom        (geom)
   );

   // Item decode, cursor state, scroll and clear sweeps, result register.
   tte_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_char_byte     (req_char_byte),
      .req_fill_color    (req_fill_color),
      .req_read_index    (req_read_index),
      .geom              (geom),
      .cur_row           (cur_row),
      .cur_col           (cur_col),
      .mem_req           (mem_req),
      .rd_data           (rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_cell_index    (rsp_cell_index),
      .rsp_cell_written  (rsp_cell_written),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_current_color (rsp_current_color),
      .rsp_flush_request (rsp_flush_request),
      .rsp_scrolled      (rsp_scrolled)
   );

   // Cell buffer.
   tte_cell_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

`ifndef NO_ASSERTIONS
   // One item at a time: an accepted item holds off the next one.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine accepted a second item while busy");

   // A scroll always leaves the cursor at the start of a row.
   a_scroll_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (rsp_cursor_column == '0))
      else $error("scroll left cursor off column zero");

   // Reported cursor stays inside the effective geometry.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_row <= geom.last_row))
      else $error("cursor row beyond last row");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_column <= geom.last_col))
      else $error("cursor column beyond last column");
`endif

endmodule

[dv/tte_scoreboard_pkg.sv]
// Item and status types plus the scoreboard class for the terminal engine bench.
// The class tracks cells, cursor, color and escape state and checks each status.
// Depends on tte_pkg only.
package tte_scoreboard_pkg;
   timeunit 1ns;
   timeprecision 1ps;
   import tte_pkg::*;

   localparam logic [1:0]  ACT_UNKNOWN  = 2'd3;
   localparam int unsigned REPORT_LIMIT = 40;

   typedef struct packed {
      logic [1:0]        action;
      logic [7:0]        char_byte;
      logic [7:0]        fill_color;
      logic [ADDR_W-1:0] read_index;
   } terminal_item_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [ADDR_W-1:0] cell_index;
      logic              cell_written;
      logic [ROW_W-1:0]  row_pos;
      logic [COL_W-1:0]  col_pos;
      logic [7:0]        current_color;
      logic              flush_request;
      logic              scrolled;
   } terminal_status_type;

   class terminal_scoreboard;
      logic [CELL_W-1:0]   cells [STORE_CELLS];
      bit                  written [STORE_CELLS];
      int unsigned         row;
      int unsigned         col;
      logic [7:0]          color;
      bit                  escape_armed;
      logic [NC_W-1:0]     columns_reg;
      logic [NR_W-1:0]     rows_reg;
      terminal_status_type status_due [$];
      int unsigned         mismatches, checked;
      int unsigned         puts, clears, reads, unknowns, scrolls, flushes;

      function new();
         row          = 0;
         col          = 0;
         color        = ATTRIBUTE_RESET;
         escape_armed = 1'b0;
         columns_reg  = COLUMNS_RESET;
         rows_reg     = ROWS_RESET;
      endfunction

      function void write_register(logic slot, logic [7:0] value);
         if (slot == CSR_COLUMNS) begin
            columns_reg = value;
         end else begin
            rows_reg = value[NR_W-1:0];
         end
      endfunction

      // Out-of-range geometry saturates to the nearest legal size.
      function int unsigned live_columns();
         if (columns_reg == 0) return 1;
         if (int'(columns_reg) > MAX_COLUMNS) return MAX_COLUMNS;
         return int'(columns_reg);
      endfunction

      function int unsigned live_rows();
         if (rows_reg == 0) return 1;
         if (int'(rows_reg) > MAX_ROWS) return MAX_ROWS;
         return int'(rows_reg);
      endfunction

      // Go to column 0 of the next row; at the bottom, shift every row up by one.
      function bit next_line(int unsigned nc, int unsigned nr);
         col = 0;
         if (row + 1 >= nr) begin
            for (int unsigned i = 0; i + nc < nc * nr; i++) begin
               cells[i]   = cells[i + nc];
               written[i] = written[i + nc];
            end
            return 1'b1;
         end
         row++;
         return 1'b0;
      endfunction

      function void note_item(terminal_item_type it);
         int unsigned         nc, nr, spot;
         terminal_status_type s;
         nc = live_columns();
         nr = live_rows();
         s  = '0;
         if (row >= nr) row = nr - 1;
         if (col >= nc) col = nc - 1;
         case (it.action)
            ACT_PUT: begin
               puts++;
               if (escape_armed) begin
                  color        = it.char_byte;
                  escape_armed = 1'b0;
               end else if (it.char_byte == CH_NEWLINE) begin
                  s.scrolled = next_line(nc, nr);
               end else if (it.char_byte == CH_BACKSPACE) begin
                  if (col != 0) begin
                     col--;
                  end else if (row != 0) begin
                     col = nc - 1;
                     row--;
                  end
               end else if (it.char_byte == CH_FLUSH) begin
                  s.flush_request = 1'b1;
               end else if (it.char_byte == CH_ESCAPE) begin
                  escape_armed = 1'b1;
               end else begin
                  spot          = row * nc + col;
                  cells[spot]   = {color, it.char_byte};
                  written[spot] = 1'b1;
                  s.cell_value   = cells[spot];
                  s.cell_index   = spot[ADDR_W-1:0];
                  s.cell_written = 1'b1;
                  col++;
                  if (col >= nc) s.scrolled = next_line(nc, nr);
               end
            end
            ACT_CLEAR: begin
               clears++;
               color = it.fill_color;
               for (int unsigned i = 0; i < nc * nr; i++) begin
                  cells[i]   = {color, CH_SPACE};
                  written[i] = 1'b1;
               end
               row = 0;
               col = 0;
            end
            ACT_READ: begin
               reads++;
               s.cell_index = it.read_index;
               s.cell_value = cells[it.read_index];
            end
            default: begin
               unknowns++;
            end
         endcase
         s.row_pos       = row[ROW_W-1:0];
         s.col_pos       = col[COL_W-1:0];
         s.current_color = color;
         if (s.scrolled) scrolls++;
         if (s.flush_request) flushes++;
         status_due.push_back(s);
      endfunction

      // Pick a cell that holds a known value; the lowest and highest get extra weight.
      function bit pick_read_slot(output logic [ADDR_W-1:0] slot);
         int          lo, hi;
         int unsigned roll, probe;
         lo   = -1;
         hi   = -1;
         slot = '0;
         foreach (written[i]) begin
            if (written[i]) begin
               if (lo < 0) lo = i;
               hi = i;
            end
         end
         if (lo < 0) return 1'b0;
         roll = $urandom_range(0, 7);
         slot = (roll == 0) ? lo[ADDR_W-1:0] : hi[ADDR_W-1:0];
         if (roll < 2) return 1'b1;
         repeat (32) begin
            probe = $urandom_range(lo, hi);
            if (written[probe]) begin
               slot = probe[ADDR_W-1:0];
               return 1'b1;
            end
         end
         return 1'b1;
      endfunction

      task report(string what, logic [15:0] want, logic [15:0] got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch at result %0d: %s expected 0x%0h, got 0x%0h",
                     checked, what, want, got);
      endtask

      task check_result(terminal_status_type got);
         terminal_status_type want;
         if (status_due.size() == 0) begin
            report("result with no item outstanding, cell_value", '0, got.cell_value);
            return;
         end
         want = status_due.pop_front();
         checked++;
         if (got.cell_value !== want.cell_value)
            report("cell_value", want.cell_value, got.cell_value);
         if (got.cell_index !== want.cell_index)
            report("cell_index", want.cell_index, got.cell_index);
         if (got.cell_written !== want.cell_written)
            report("cell_written", want.cell_written, got.cell_written);
         if (got.row_pos !== want.row_pos)
            report("row_pos", want.row_pos, got.row_pos);
         if (got.col_pos !== want.col_pos)
            report("col_pos", want.col_pos, got.col_pos);
         if (got.current_color !== want.current_color)
            report("current_color", want.current_color, got.current_color);
         if (got.flush_request !== want.flush_request)
            report("flush_request", want.flush_request, got.flush_request);
         if (got.scrolled !== want.scrolled)
            report("scrolled", want.scrolled, got.scrolled);
      endtask
   endclass

endpackage

[dv/tb.sv]
// Self-checking bench for text_terminal_char_engine: bursty item traffic, patterned
// result stalls and several screen geometries, checked by the terminal scoreboard.
// Depends on tte_pkg, tte_scoreboard_pkg and the engine RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tte_pkg::*;
   import tte_scoreboard_pkg::*;

   localparam int unsigned ITEM_W     = $bits(terminal_item_type);
   localparam int unsigned LONG_HOLD  = 400;        // cycles of the one long result hold-off
   localparam int unsigned HOLD_AT    = 110;        // results checked before that hold-off
   localparam int unsigned SETTLE     = 8;          // idle cycles before a register write
   localparam int unsigned DRAIN      = 24;         // quiet cycles after the last result
   localparam int unsigned TIMEOUT_NS = 20_000_000; // several times the slowest sane run

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_EVERY_THIRD,
      STALL_HEAVY
   } stall_pattern_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [1:0]        req_action       = ACT_PUT;
   logic [7:0]        req_char_byte    = 8'h00;
   logic [7:0]        req_fill_color   = 8'h00;
   logic [ADDR_W-1:0] req_read_index   = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [CELL_W-1:0] rsp_cell_value;
   logic [ADDR_W-1:0] rsp_cell_index;
   logic              rsp_cell_written;
   logic [ROW_W-1:0]  rsp_cursor_row;
   logic [COL_W-1:0]  rsp_cursor_column;
   logic [7:0]        rsp_current_color;
   logic              rsp_flush_request;
   logic              rsp_scrolled;
   logic              csr_write_enable = 1'b0;
   logic              csr_index        = CSR_COLUMNS;
   logic [7:0]        csr_write_data   = 8'h00;

   terminal_scoreboard board = new();
   int unsigned        burst_left = 0;

   text_terminal_char_engine uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_char_byte     (req_char_byte),
      .req_fill_color    (req_fill_color),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_cell_index    (rsp_cell_index),
      .rsp_cell_written  (rsp_cell_written),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_current_color (rsp_current_color),
      .rsp_flush_request (rsp_flush_request),
      .rsp_scrolled      (rsp_scrolled),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #4 clock = ~clock;

   // Check every status item the moment it is taken; outputs still hold their
   // pre-edge values here because the block updates them with nonblocking writes.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_cell_value, rsp_cell_index, rsp_cell_written,
                             rsp_cursor_row, rsp_cursor_column, rsp_current_color,
                             rsp_flush_request, rsp_scrolled});
   end

   // Result side: switch stall patterns after stretches of random length, and once
   // hold off for a long stretch so the engine backs up and stalls the item side.
   initial begin : result_side
      stall_pattern_type pattern;
      int unsigned       stretch, hold_left, beat;
      bit                held, stall_next;
      pattern   = STALL_NONE;
      stretch   = 0;
      hold_left = 0;
      beat      = 0;
      held      = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         beat++;
         if (!held && board.checked >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (stretch == 0) begin
            pattern = stall_pattern_type'($urandom_range(0, 3));
            stretch = $urandom_range(16, 96);
         end
         stretch--;
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            case (pattern)
               STALL_NONE:        stall_next = 1'b0;
               STALL_LIGHT:       stall_next = ($urandom_range(0, 99) < 30);
               STALL_EVERY_THIRD: stall_next = (beat % 3 == 0);
               default:           stall_next = ($urandom_range(0, 99) < 75);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   function automatic terminal_item_type item(logic [1:0] act, logic [7:0] ch,
                                              logic [7:0] fill, logic [ADDR_W-1:0] where);
      return '{action: act, char_byte: ch, fill_color: fill, read_index: where};
   endfunction

   // Random content in every field, so the fields an action ignores get noise too.
   function automatic terminal_item_type random_item(logic [1:0] act);
      terminal_item_type it;
      it        = ITEM_W'($urandom);
      it.action = act;
      return it;
   endfunction

   // Offer one item and hold it until taken. Bursts of random length with random
   // gaps between them; a quarter of the bursts follow on with no gap at all.
   task automatic offer(terminal_item_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_action     <= it.action;
      req_char_byte  <= it.char_byte;
      req_fill_color <= it.fill_color;
      req_read_index <= it.read_index;
      do @(posedge clock); while (req_stall);
      board.note_item(it);
   endtask

   // Drain the engine, then write both geometry registers back to back.
   task automatic write_geometry(logic [7:0] columns, logic [7:0] rows);
      req_valid <= 1'b0;
      while (board.status_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_COLUMNS;
      csr_write_data   <= columns;
      @(posedge clock);
      csr_index        <= CSR_ROWS;
      csr_write_data   <= rows;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.write_register(CSR_COLUMNS, columns);
      board.write_register(CSR_ROWS, rows);
   endtask

   // Hand-picked items at the reset geometry (80 x 25). Reads only touch cells
   // that a clear or a put has already written.
   task automatic directed_items();
      offer(item(ACT_UNKNOWN, 8'hff, 8'hff, 12'hfff)); // unknown action: no change
      offer(item(ACT_PUT, CH_BACKSPACE, 8'h00, 12'h000)); // backspace at the origin
      offer(item(ACT_PUT, CH_FLUSH, 8'h00, 12'h000));
      offer(item(ACT_CLEAR, 8'h00, 8'h00, 12'h000));      // lowest fill color
      offer(item(ACT_READ, 8'h00, 8'h00, 12'h000));
      offer(item(ACT_PUT, 8'hff, 8'h00, 12'h000));        // byte extremes as cells
      offer(item(ACT_PUT, 8'h00, 8'h00, 12'h000));
      // armed escape swallows a control byte as the new color
      offer(item(ACT_PUT, CH_ESCAPE, 8'h00, 12'h000));
      offer(item(ACT_PUT, CH_NEWLINE, 8'h00, 12'h000));
      // escape stays armed across a clear and a read
      offer(item(ACT_PUT, CH_ESCAPE, 8'h00, 12'h000));
      offer(item(ACT_CLEAR, 8'h00, 8'hff, 12'h000));
      offer(item(ACT_READ, 8'h00, 8'h00, 12'd1999));
      offer(item(ACT_PUT, 8'h41, 8'h00, 12'h000));
      offer(item(ACT_PUT, 8'h78, 8'h00, 12'h000));
      offer(item(ACT_PUT, CH_BACKSPACE, 8'h00, 12'h000));
      offer(item(ACT_PUT, CH_NEWLINE, 8'h00, 12'h000));
      offer(item(ACT_PUT, CH_BACKSPACE, 8'h00, 12'h000)); // wrap to previous row end
      offer(item(ACT_PUT, 8'h79, 8'h00, 12'h000));        // fills last column, wraps
      offer(item(ACT_READ, 8'h00, 8'h00, 12'd79));
      offer(item(ACT_PUT, CH_ESCAPE, 8'h00, 12'h000));
      offer(item(ACT_PUT, 8'h00, 8'h00, 12'h000));
      // leave the cursor off the origin so the next shrink has to clamp it
      offer(item(ACT_PUT, 8'h7a, 8'h00, 12'h000));
   endtask

   // Mostly well-formed text with controls and color escapes; some escapes are
   // left dangling, and a few clears, reads and unknown actions are mixed in.
   task automatic random_items(int unsigned count);
      terminal_item_type it;
      logic [ADDR_W-1:0] slot;
      int unsigned       pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         it   = random_item(ACT_PUT);
         if (pick < 12) begin
            it.char_byte = CH_NEWLINE;
         end else if (pick < 20) begin
            it.char_byte = CH_BACKSPACE;
         end else if (pick < 24) begin
            it.char_byte = CH_FLUSH;
         end else if (pick < 31) begin
            it.char_byte = CH_ESCAPE;
            if ($urandom_range(0, 3) != 0) begin
               offer(it);
               it = random_item(ACT_PUT); // color byte, any value
            end
         end else if (pick < 36) begin
            it.action = ACT_CLEAR;
         end else if (pick < 43) begin
            if (board.pick_read_slot(slot)) begin
               it.action     = ACT_READ;
               it.read_index = slot;
            end
         end else if (pick < 45) begin
            it.action = ACT_UNKNOWN;
         end
         offer(it);
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();
      random_items(60);
      // both registers below range: a single-cell screen
      write_geometry(8'd0, 8'd0);
      random_items(80);
      // both registers above range: the whole store; clear it so any cell reads back
      write_geometry(8'd255, 8'd255);
      offer(item(ACT_CLEAR, 8'h00, 8'h5a, 12'h000));
      random_items(50);
      write_geometry(8'd1, 8'd32);
      random_items(80);
      write_geometry(8'd128, 8'd1);
      random_items(60);
      write_geometry(8'd3, 8'd2);
      random_items(100);
      repeat (3) begin
         write_geometry(8'($urandom_range(2, 16)), 8'($urandom_range(2, 8)));
         random_items(100);
      end
      write_geometry(COLUMNS_RESET, 8'(ROWS_RESET));
      random_items(40);
      req_valid <= 1'b0;
      while (board.status_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("covered %0d puts, %0d clears, %0d reads, %0d unknown actions over 9 geometries",
               board.puts, board.clears, board.reads, board.unknowns);
      $display("saw %0d scrolls and %0d flush requests; %0d results checked, %0d mismatches",
               board.scrolls, board.flushes, board.checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", board.status_due.size());
      $display("FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/core/tte_pkg.sv
rtl/core/tte_cell_ram.sv
rtl/core/tte_geom.sv
rtl/core/tte_ctrl.sv
rtl/core/text_terminal_char_engine.sv
dv/tte_scoreboard_pkg.sv
dv/tb.sv
